// File: hdl/che_pkg.sv
// ----------------------------------------------------------------------------
// che_pkg
// Types, constants and helpers shared by the chunk header encoder modules.
// ----------------------------------------------------------------------------
package che_pkg;

    // Operation codes
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_CONT   = 1'b1;

    // Header formats (the two top bits of the basic header)
    localparam logic [1:0] FMT_FULL      = 2'd0;
    localparam logic [1:0] FMT_NO_STREAM = 2'd1;
    localparam logic [1:0] FMT_TIME_ONLY = 2'd2;
    localparam logic [1:0] FMT_NONE      = 2'd3;

    // Timestamp field saturation / extended marker
    localparam logic [23:0] TS_MAX = 24'hFFFFFF;

    // Basic header thresholds
    localparam logic [16:0] BASIC_ONE_LIMIT = 17'd64;
    localparam logic [16:0] BASIC_TWO_LIMIT = 17'd320;
    localparam logic [16:0] CHAN_BIAS       = 17'd64;
    localparam logic [5:0]  BASIC_ESC_WIDE  = 6'd1;

    // Body lengths per format
    localparam logic [3:0] BODY_LEN_FULL      = 4'd11;
    localparam logic [3:0] BODY_LEN_NO_STREAM = 4'd7;
    localparam logic [3:0] BODY_LEN_TIME_ONLY = 4'd3;
    localparam logic [3:0] BODY_LEN_NONE      = 4'd0;

    localparam logic [23:0] CHUNK_SIZE_RST = 24'd128;

    // One history slot entry
    typedef struct packed {
        logic [16:0] channel;
        logic [7:0]  msg_type;
        logic [23:0] length;
        logic [31:0] time_abs;
        logic [23:0] time_field;
        logic [31:0] stream;
        logic [23:0] offset;
    } t_slot_rec;

    // Basic header bytes and count (1..3)
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] len;
    } t_basic;

    // Everything the byte emitter needs for one header
    typedef struct packed {
        t_basic           basic;
        logic [10:0][7:0] body;
        logic [3:0]       body_len;
        logic             ext;
        logic [31:0]      ext_time;
    } t_emit_load;

    // Basic header: one, two or three bytes depending on the channel
    function automatic t_basic basic_hdr(input logic [16:0] chan, input logic [1:0] fmt);
        t_basic      b;
        logic [16:0] c;
        c    = chan - CHAN_BIAS;
        b.b0 = {fmt, 6'd0};
        b.b1 = c[7:0];
        b.b2 = c[15:8];
        if (chan < BASIC_ONE_LIMIT) begin
            b.b0  = {fmt, chan[5:0]};
            b.len = 2'd1;
        end else if (chan < BASIC_TWO_LIMIT) begin
            b.len = 2'd2;
        end else begin
            b.b0  = {fmt, BASIC_ESC_WIDE};
            b.len = 2'd3;
        end
        return b;
    endfunction

endpackage

// File: hdl/che_slot_mem.sv
// ----------------------------------------------------------------------------
// che_slot_mem
// Slot history memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module che_slot_mem
    import che_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_slot_rec     o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_slot_rec     i_wr_data
);

    t_slot_rec r_mem [DEPTH];
    t_slot_rec r_rd_data;

    // Read before write on a same-address collision; the caller forwards
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/che_emit.sv
// ----------------------------------------------------------------------------
// che_emit
// Byte emitter: walks basic header, body and extended timestamp sections,
// one byte per cycle while i_stall is low, and doubles as the output register.
// ----------------------------------------------------------------------------
module che_emit
    import che_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_emit_load i_load_data,
    output logic       o_free,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last,
    input  logic       i_stall
);

    typedef enum logic [2:0] {
        SEC_BASIC = 3'b001,
        SEC_BODY  = 3'b010,
        SEC_EXT   = 3'b100
    } t_sec;

    logic       r_busy;
    t_sec       r_sec;
    t_sec       n_sec;
    logic [3:0] r_idx;
    t_emit_load r_ld;

    logic [7:0] cur_byte;
    logic       sec_last;
    logic       more;
    logic       is_last;

    // Current byte and end-of-section detection
    always_comb begin
        cur_byte = '0;
        sec_last = 1'b1;
        more     = 1'b0;
        n_sec    = SEC_EXT;
        unique case (r_sec)
            SEC_BASIC: begin
                case (r_idx[1:0])
                    2'd0:    cur_byte = r_ld.basic.b0;
                    2'd1:    cur_byte = r_ld.basic.b1;
                    default: cur_byte = r_ld.basic.b2;
                endcase
                sec_last = (r_idx[1:0] == (r_ld.basic.len - 2'd1));
                more     = (r_ld.body_len != BODY_LEN_NONE) || r_ld.ext;
                n_sec    = (r_ld.body_len != BODY_LEN_NONE) ? SEC_BODY : SEC_EXT;
            end
            SEC_BODY: begin
                cur_byte = r_ld.body[r_idx];
                sec_last = (r_idx == (r_ld.body_len - 4'd1));
                more     = r_ld.ext;
            end
            SEC_EXT: begin
                case (r_idx[1:0])
                    2'd0:    cur_byte = r_ld.ext_time[31:24];
                    2'd1:    cur_byte = r_ld.ext_time[23:16];
                    2'd2:    cur_byte = r_ld.ext_time[15:8];
                    default: cur_byte = r_ld.ext_time[7:0];
                endcase
                sec_last = (r_idx[1:0] == 2'd3);
            end
            default: begin
                cur_byte = '0;
            end
        endcase
        is_last = sec_last && !more;
    end

    assign o_free  = !r_busy || (is_last && !i_stall);
    assign o_valid = r_busy;
    assign o_byte  = cur_byte;
    assign o_last  = is_last;

    // Section / index sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sec  <= SEC_BASIC;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_sec  <= SEC_BASIC;
            r_idx  <= '0;
        end else if (r_busy && !i_stall) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else if (sec_last) begin
                r_sec <= n_sec;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // Header contents
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ld <= i_load_data;
        end
    end

endmodule

// File: hdl/chunk_header_encoder_core.sv
// ----------------------------------------------------------------------------
// chunk_header_encoder_core
// Chunk header encoder: per-slot history in a synchronous memory, header
// form selection and continuation offset update, byte-serial output.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  request  | in        | i_valid / o_stall          | i_operation .. i_msg_stream
//  header   | out       | o_valid / i_stall          | o_header_byte, o_last_byte
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_out_chunk_size
//
// A request reads its slot in the accept cycle and is resolved the next
// cycle. A header of 1 to 18 bytes goes out one byte per cycle while i_stall is
// low; the emitter sets the rate, and the next request is resolved while the
// current header drains. Requests that emit nothing retire without waiting for
// the emitter. Reset clears the slot valid bits at once; no clearing pass is
// needed. Output stall backs up through the emitter into o_stall.
// ----------------------------------------------------------------------------
module chunk_header_encoder_core
    import che_pkg::*;
#(
    parameter int HISTORY_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [5:0]  i_slot,
    input  logic [16:0] i_channel_id,
    input  logic [7:0]  i_msg_type,
    input  logic [23:0] i_msg_length,
    input  logic [31:0] i_msg_time,
    input  logic [31:0] i_msg_stream,
    // header byte channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_header_byte,
    output logic        o_last_byte,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_out_chunk_size
);

    // Only slots 0..63 are addressable by the request
    localparam int DEPTH = (HISTORY_SLOTS < 64) ? HISTORY_SLOTS : 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration register
    logic [23:0] r_chunk_size;

    // Resolve stage
    logic          r_s1_valid;
    logic          r_s1_op;
    logic [5:0]    r_s1_slot;
    logic [16:0]   r_s1_chan;
    logic [7:0]    r_s1_type;
    logic [23:0]   r_s1_len;
    logic [31:0]   r_s1_time;
    logic [31:0]   r_s1_stream;
    logic          r_byp_hit;
    t_slot_rec     r_byp_rec;
    logic [DEPTH-1:0] r_slot_valid;

    logic          accept;
    logic [AW-1:0] s1_addr;
    logic          in_range;
    t_slot_rec     mem_rd;
    t_slot_rec     rec;
    logic          v;

    // continuation path
    logic [24:0]   c_sum;
    logic          c_emit;
    logic [23:0]   c_new_off;

    // header path
    logic [31:0]   h_diff;
    logic          h_delta;
    logic [31:0]   h_tval;
    logic          h_ext;
    logic [23:0]   h_tfield;
    logic [1:0]    h_fmt;

    logic          s1_emits;
    logic          s1_go;
    logic          retire;
    logic          wr_en;
    t_slot_rec     wr_rec;
    t_emit_load    ld;
    logic          emit_free;
    logic          emit_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size <= CHUNK_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_chunk_size <= i_cfg_out_chunk_size;
        end
    end

    assign accept = i_valid && !o_stall;

    // Slot history
    che_slot_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(i_slot)),
        .o_rd_data (mem_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (s1_addr),
        .i_wr_data (wr_rec)
    );

    // Request capture with same-slot write forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp_hit  <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_byp_hit  <= wr_en && (s1_addr == AW'(i_slot));
        end else if (retire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op     <= i_operation;
            r_s1_slot   <= i_slot;
            r_s1_chan   <= i_channel_id;
            r_s1_type   <= i_msg_type;
            r_s1_len    <= i_msg_length;
            r_s1_time   <= i_msg_time;
            r_s1_stream <= i_msg_stream;
            r_byp_rec   <= wr_rec;
        end
    end

    assign s1_addr  = AW'(r_s1_slot);
    assign in_range = (7'(r_s1_slot) < 7'(DEPTH));
    assign rec      = r_byp_hit ? r_byp_rec : mem_rd;
    assign v        = in_range && r_slot_valid[s1_addr];

    // Continuation: advance offset by one chunk, emit while data remains
    always_comb begin
        c_sum  = {1'b0, rec.offset} + {1'b0, r_chunk_size};
        c_emit = v && (c_sum < {1'b0, rec.length});
        if (c_emit) begin
            c_new_off = c_sum[23:0];
        end else if (rec.length > rec.offset) begin
            c_new_off = rec.length;
        end else begin
            c_new_off = rec.offset;
        end
    end

    // Header: pick the form from the slot history
    always_comb begin
        h_diff   = r_s1_time - rec.time_abs;
        h_delta  = v && (r_s1_stream == rec.stream) && (r_s1_time >= rec.time_abs);
        h_tval   = h_delta ? h_diff : r_s1_time;
        h_ext    = (h_tval >= {8'd0, TS_MAX});
        h_tfield = h_ext ? TS_MAX : h_tval[23:0];
        if (!h_delta) begin
            h_fmt = FMT_FULL;
        end else if ((r_s1_type == rec.msg_type) && (r_s1_len == rec.length)) begin
            h_fmt = (h_tfield == rec.time_field) ? FMT_NONE : FMT_TIME_ONLY;
        end else begin
            h_fmt = FMT_NO_STREAM;
        end
    end

    // Emitter load data and slot write-back
    always_comb begin
        ld          = '0;
        wr_rec      = rec;
        if (r_s1_op == OP_CONT) begin
            ld.basic    = basic_hdr(rec.channel, FMT_NONE);
            ld.body_len = BODY_LEN_NONE;
            ld.ext      = (rec.time_field == TS_MAX);
            ld.ext_time = rec.time_abs;
            wr_rec.offset = c_new_off;
            s1_emits    = c_emit;
        end else begin
            ld.basic    = basic_hdr(r_s1_chan, h_fmt);
            ld.body[0]  = h_tfield[23:16];
            ld.body[1]  = h_tfield[15:8];
            ld.body[2]  = h_tfield[7:0];
            ld.body[3]  = r_s1_len[23:16];
            ld.body[4]  = r_s1_len[15:8];
            ld.body[5]  = r_s1_len[7:0];
            ld.body[6]  = r_s1_type;
            ld.body[7]  = r_s1_stream[7:0];
            ld.body[8]  = r_s1_stream[15:8];
            ld.body[9]  = r_s1_stream[23:16];
            ld.body[10] = r_s1_stream[31:24];
            case (h_fmt)
                FMT_FULL:      ld.body_len = BODY_LEN_FULL;
                FMT_NO_STREAM: ld.body_len = BODY_LEN_NO_STREAM;
                FMT_TIME_ONLY: ld.body_len = BODY_LEN_TIME_ONLY;
                default:       ld.body_len = BODY_LEN_NONE;
            endcase
            ld.ext      = h_ext;
            ld.ext_time = h_tval;
            wr_rec.channel    = r_s1_chan;
            wr_rec.msg_type   = r_s1_type;
            wr_rec.length     = r_s1_len;
            wr_rec.time_abs   = r_s1_time;
            wr_rec.time_field = h_tfield;
            wr_rec.stream     = r_s1_stream;
            wr_rec.offset     = '0;
            s1_emits          = in_range;
        end
    end

    // Hand-off: an item leaves when it emits nothing or the emitter frees up
    assign s1_go     = !s1_emits || emit_free;
    assign retire    = r_s1_valid && s1_go;
    assign emit_load = r_s1_valid && s1_emits && emit_free;
    assign wr_en     = retire && in_range && ((r_s1_op == OP_HEADER) || v);
    assign o_stall   = r_s1_valid && !s1_go;

    // Slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (retire && in_range && (r_s1_op == OP_HEADER)) begin
            r_slot_valid[s1_addr] <= 1'b1;
        end
    end

    che_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (emit_load),
        .i_load_data (ld),
        .o_free      (emit_free),
        .o_valid     (o_valid),
        .o_byte      (o_header_byte),
        .o_last      (o_last_byte),
        .i_stall     (i_stall)
    );

endmodule

// File: hdl/che_checker.sv
// ----------------------------------------------------------------------------
// che_checker
// Port-level checks on the header byte channel, bound to the core.
// ----------------------------------------------------------------------------
module che_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_header_byte,
    input logic       o_last_byte
);

    // bytes delivered so far in the current header
    logic [4:0] r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (o_valid && !i_stall) begin
            r_run <= o_last_byte ? 5'd0 : r_run + 5'd1;
        end
    end

    // Stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_header_byte) && $stable(o_last_byte))
        else $error("header item changed while stalled");

    // Nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // No header runs past 18 bytes
    a_max_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_byte |-> r_run < 5'd17)
        else $error("header longer than 18 bytes");

endmodule

bind chunk_header_encoder_core che_checker u_che_checker (.*);

// File: dv/chunk_header_encoder_core_tb.sv
// ----------------------------------------------------------------------------
// chunk_header_encoder_core_tb
// Self-checking bench for the chunk header encoder. A directed table covers
// the basic-header widths, all four header forms, extended timestamps and
// the continuation cases; random traffic follows under several chunk sizes.
// Header bytes are checked against inline bytes or a per-slot history model.
// ----------------------------------------------------------------------------
module chunk_header_encoder_core_tb
    import che_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 64;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 33;
    localparam int DRAIN_WAIT  = 8;
    localparam int TAIL_WAIT   = 40;
    localparam int LONG_HOLD   = 300;
    localparam int LIMIT       = 500000;
    localparam int MAX_REPORTS = 10;

    // One request item plus an optional hand-written expectation
    typedef struct {
        logic         op;
        logic [5:0]   slot;
        logic [16:0]  chan;
        logic [7:0]   mtype;
        logic [23:0]  len;
        logic [31:0]  mtime;
        logic [31:0]  stream;
        int           n_typed;      // -1: use the history model
        logic [143:0] typed_bytes;  // first byte leftmost, last byte in [7:0]
    } t_req;

    typedef struct packed {
        logic [7:0] hbyte;
        logic       last;
    } t_hdr_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_header_byte;
    logic        o_last_byte;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_out_chunk_size = '0;
    t_req        cur_req;

    // history model
    logic        hist_valid [SLOTS];
    logic [16:0] hist_chan [SLOTS];
    logic [7:0]  hist_type [SLOTS];
    logic [23:0] hist_len [SLOTS];
    logic [31:0] hist_time [SLOTS];
    logic [23:0] hist_tfield [SLOTS];
    logic [31:0] hist_stream [SLOTS];
    logic [23:0] hist_off [SLOTS];
    logic [23:0] chunk_size;
    logic [7:0]  built [$];

    t_hdr_byte   pending_bytes [$];
    int          mismatches = 0;
    int          bytes_seen = 0;
    int          cycle_count = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          burst_left = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    chunk_header_encoder_core u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_operation          (cur_req.op),
        .i_slot               (cur_req.slot),
        .i_channel_id         (cur_req.chan),
        .i_msg_type           (cur_req.mtype),
        .i_msg_length         (cur_req.len),
        .i_msg_time           (cur_req.mtime),
        .i_msg_stream         (cur_req.stream),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_header_byte        (o_header_byte),
        .o_last_byte          (o_last_byte),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_out_chunk_size (i_cfg_out_chunk_size)
    );

    // ------------------------------------------------------------------
    // Header byte builders
    // ------------------------------------------------------------------
    function automatic void put_byte(input logic [7:0] b);
        built.push_back(b);
    endfunction

    function automatic void put_be24(input logic [23:0] v);
        put_byte(v[23:16]);
        put_byte(v[15:8]);
        put_byte(v[7:0]);
    endfunction

    function automatic void put_be32(input logic [31:0] v);
        put_byte(v[31:24]);
        put_be24(v[23:0]);
    endfunction

    // 1, 2 or 3 byte basic header
    function automatic void put_basic(input logic [16:0] chan, input logic [1:0] fmt);
        logic [16:0] c;
        c = chan - CHAN_BIAS;
        if (chan < BASIC_ONE_LIMIT) begin
            put_byte({fmt, chan[5:0]});
        end else if (chan < BASIC_TWO_LIMIT) begin
            put_byte({fmt, 6'd0});
            put_byte(c[7:0]);
        end else begin
            put_byte({fmt, BASIC_ESC_WIDE});
            put_byte(c[7:0]);
            put_byte(c[15:8]);
        end
    endfunction

    // Builds the header bytes one request causes and updates the slot history
    function automatic void encode_request(input t_req r);
        logic [23:0] rem;
        logic [23:0] adv;
        logic        delta;
        logic [31:0] tval;
        logic [23:0] tfield;
        logic [1:0]  fmt;
        int          s;
        built.delete();
        s = r.slot;
        if (r.op == OP_CONT) begin
            if (!hist_valid[s]) return;
            rem = (hist_len[s] > hist_off[s]) ? hist_len[s] - hist_off[s] : 24'd0;
            adv = (chunk_size < rem) ? chunk_size : rem;
            hist_off[s] = hist_off[s] + adv;
            // message done: nothing more to announce
            if (hist_off[s] >= hist_len[s]) return;
            put_basic(hist_chan[s], FMT_NONE);
            if (hist_tfield[s] == TS_MAX) put_be32(hist_time[s]);
            return;
        end
        delta = hist_valid[s] && (r.stream == hist_stream[s]) && (r.mtime >= hist_time[s]);
        tval = delta ? r.mtime - hist_time[s] : r.mtime;
        tfield = (tval >= {8'd0, TS_MAX}) ? TS_MAX : tval[23:0];
        fmt = FMT_FULL;
        if (delta) begin
            if (r.mtype == hist_type[s] && r.len == hist_len[s]) begin
                fmt = (tfield == hist_tfield[s]) ? FMT_NONE : FMT_TIME_ONLY;
            end else begin
                fmt = FMT_NO_STREAM;
            end
        end
        put_basic(r.chan, fmt);
        if (fmt != FMT_NONE) begin
            put_be24(tfield);
            if (fmt != FMT_TIME_ONLY) begin
                put_be24(r.len);
                put_byte(r.mtype);
                if (fmt == FMT_FULL) begin
                    // stream id goes out little-endian
                    put_byte(r.stream[7:0]);
                    put_byte(r.stream[15:8]);
                    put_byte(r.stream[23:16]);
                    put_byte(r.stream[31:24]);
                end
            end
        end
        if (tfield == TS_MAX) put_be32(tval);
        hist_valid[s]  = 1'b1;
        hist_chan[s]   = r.chan;
        hist_type[s]   = r.mtype;
        hist_len[s]    = r.len;
        hist_time[s]   = r.mtime;
        hist_tfield[s] = tfield;
        hist_stream[s] = r.stream;
        hist_off[s]    = '0;
    endfunction

    function automatic t_req mk_req(input logic op, input logic [5:0] slot,
                                    input logic [16:0] chan, input logic [7:0] mtype,
                                    input logic [23:0] len, input logic [31:0] mtime,
                                    input logic [31:0] stream);
        t_req r;
        r.op = op;
        r.slot = slot;
        r.chan = chan;
        r.mtype = mtype;
        r.len = len;
        r.mtime = mtime;
        r.stream = stream;
        r.n_typed = -1;
        r.typed_bytes = '0;
        return r;
    endfunction

    // Random request, mostly built on the slot's history so that the delta
    // forms and long continuation runs come up often
    function automatic t_req gen_item();
        t_req       r;
        int         pick;
        logic [5:0] s;
        r = mk_req(1'($urandom), 6'($urandom), 17'($urandom), 8'($urandom),
                   24'($urandom), $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) return r;  // pure noise
        s = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 5));
        r.slot = s;
        if (hist_valid[s] && pick < 50) begin
            r.op = OP_CONT;
            return r;
        end
        r.op = OP_HEADER;
        case ($urandom_range(0, 4))
            0: if (hist_valid[s]) r.chan = hist_chan[s];
            1: r.chan = 17'($urandom_range(0, 63));
            2: r.chan = 17'($urandom_range(64, 319));
            3: r.chan = 17'($urandom_range(320, 65599));
            default: ;
        endcase
        if (hist_valid[s] && $urandom_range(0, 3) != 0) r.stream = hist_stream[s];
        if (hist_valid[s] && $urandom_range(0, 99) < 60) begin
            r.mtype = hist_type[s];
            r.len = hist_len[s];
        end else if ($urandom_range(0, 4) != 0) begin
            r.len = 24'($urandom_range(0, 700));
        end
        if (hist_valid[s]) begin
            case ($urandom_range(0, 5))
                0: r.mtime = hist_time[s] + {8'd0, hist_tfield[s]};
                1: r.mtime = hist_time[s] + 32'($urandom_range(0, 1000));
                2: r.mtime = hist_time[s] + {8'd0, TS_MAX} + 32'($urandom_range(0, 3));
                3: r.mtime = hist_time[s] - 32'($urandom_range(1, 100));
                4: r.mtime = $urandom;
                default: r.mtime = hist_time[s];
            endcase
        end else if ($urandom_range(0, 1) == 0) begin
            r.mtime = 32'($urandom_range(0, 'hFFFF));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offers one item, holds it until accepted
    // ------------------------------------------------------------------
    task automatic send_req(input t_req r);
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        cur_req <= r;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic stop_requests();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // wait until every expected byte is out, then let the pipe settle
    task automatic wait_idle();
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_chunk_size(input logic [23:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_out_chunk_size <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output stall: random bursts plus an occasional long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            i_stall <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            burst_left <= $urandom_range(0, 10);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Prediction on accepted items, checking on accepted header bytes
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_hdr_byte want;
        int        k;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) chunk_size = i_cfg_out_chunk_size;
            if (i_valid && !o_stall) begin
                encode_request(cur_req);
                if (cur_req.n_typed >= 0) begin
                    for (k = 0; k < cur_req.n_typed; k++) begin
                        want.hbyte = cur_req.typed_bytes[(cur_req.n_typed - 1 - k) * 8 +: 8];
                        want.last = (k == cur_req.n_typed - 1);
                        pending_bytes.push_back(want);
                    end
                end else begin
                    for (k = 0; k < built.size(); k++) begin
                        want.hbyte = built[k];
                        want.last = (k == built.size() - 1);
                        pending_bytes.push_back(want);
                    end
                end
            end
            if (o_valid && !i_stall) begin
                if (pending_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("byte %0d: unexpected %02h last %0b", bytes_seen,
                                 o_header_byte, o_last_byte);
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_header_byte !== want.hbyte || o_last_byte !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                                     bytes_seen, want.hbyte, want.last,
                                     o_header_byte, o_last_byte);
                    end
                end
                bytes_seen++;
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_req        dir_tab [$];
        t_req        r;
        logic [23:0] chunk_plan [PHASES];
        for (int i = 0; i < SLOTS; i++) begin
            hist_valid[i]  = 1'b0;
            hist_chan[i]   = '0;
            hist_type[i]   = '0;
            hist_len[i]    = '0;
            hist_time[i]   = '0;
            hist_tfield[i] = '0;
            hist_stream[i] = '0;
            hist_off[i]    = '0;
        end
        chunk_size = CHUNK_SIZE_RST;
        cur_req = mk_req(OP_HEADER, '0, '0, '0, '0, '0, '0);

        // Directed table. Fresh slots and extremes carry their bytes inline.
        r = mk_req(OP_HEADER, 6'd0, 17'd3, 8'h08, 24'h10, 32'd1, 32'h04030201);
        r.n_typed = 12;
        r.typed_bytes = 144'h03_000001_000010_08_01020304;
        dir_tab.push_back(r);
        // continuation on a slot never written: silent
        r = mk_req(OP_CONT, 6'd5, '0, '0, '0, '0, '0);
        r.n_typed = 0;
        dir_tab.push_back(r);
        r = mk_req(OP_HEADER, 6'd63, 17'd0, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        r.n_typed = 16;
        r.typed_bytes = 144'h00_FFFFFF_FFFFFF_FF_FFFFFFFF_FFFFFFFF;
        dir_tab.push_back(r);
        r = mk_req(OP_HEADER, 6'd62, 17'd65599, 8'h00, 24'h0, 32'h0, 32'h0);
        r.n_typed = 14;
        r.typed_bytes = 144'h01FFFF_000000_000000_00_00000000;
        dir_tab.push_back(r);
        // channel one collides with the escape code
        dir_tab.push_back(mk_req(OP_HEADER, 6'd1, 17'd1, 8'h14, 24'd300, 32'd1000, 32'd7));
        dir_tab.push_back(mk_req(OP_HEADER, 6'd2, 17'd63, 8'h09, 24'd50, 32'd20, 32'd1));
        dir_tab.push_back(mk_req(OP_HEADER, 6'd3, 17'd64, 8'h09, 24'd200, 32'd20, 32'd1));
        dir_tab.push_back(mk_req(OP_HEADER, 6'd4, 17'd319, 8'h09, 24'd50, 32'd20, 32'd1));
        dir_tab.push_back(mk_req(OP_HEADER, 6'd6, 17'd320, 8'h12, 24'd500, 32'd20, 32'd1));
        // channel above range keeps only the low 16 bits
        dir_tab.push_back(mk_req(OP_HEADER, 6'd7, 17'h1FFFF, 8'h12, 24'd5, 32'd9, 32'd2));
        // delta forms on slot 0: time only, none, no stream
        dir_tab.push_back(mk_req(OP_HEADER, 6'd0, 17'd3, 8'h08, 24'h10, 32'd11, 32'h04030201));
        dir_tab.push_back(mk_req(OP_HEADER, 6'd0, 17'd3, 8'h08, 24'h10, 32'd21, 32'h04030201));
        dir_tab.push_back(mk_req(OP_HEADER, 6'd0, 17'd3, 8'h09, 24'h10, 32'd30, 32'h04030201));
        // time going backwards, then a stream change
        dir_tab.push_back(mk_req(OP_HEADER, 6'd0, 17'd3, 8'h09, 24'h10, 32'd5, 32'h04030201));
        dir_tab.push_back(mk_req(OP_HEADER, 6'd0, 17'd3, 8'h09, 24'h10, 32'd6, 32'h11111111));
        // extended delta
        dir_tab.push_back(mk_req(OP_HEADER, 6'd0, 17'd3, 8'h09, 24'h10, 32'h01000006,
                                 32'h11111111));
        // short message, continuation finds it done
        dir_tab.push_back(mk_req(OP_CONT, 6'd0, '0, '0, '0, '0, '0));
        // delta of exactly the saturation value, then a continuation run
        dir_tab.push_back(mk_req(OP_HEADER, 6'd1, 17'd1, 8'h14, 24'd300,
                                 32'd1000 + 32'h00FFFFFF, 32'd7));
        dir_tab.push_back(mk_req(OP_CONT, 6'd1, '0, '0, '0, '0, '0));
        dir_tab.push_back(mk_req(OP_CONT, 6'd1, '0, '0, '0, '0, '0));
        dir_tab.push_back(mk_req(OP_CONT, 6'd1, '0, '0, '0, '0, '0));
        dir_tab.push_back(mk_req(OP_CONT, 6'd1, '0, '0, '0, '0, '0));
        dir_tab.push_back(mk_req(OP_CONT, 6'd3, '0, '0, '0, '0, '0));
        dir_tab.push_back(mk_req(OP_CONT, 6'd6, '0, '0, '0, '0, '0));

        chunk_plan[0] = 24'd1;
        chunk_plan[1] = 24'hFFFFFF;
        chunk_plan[2] = 24'd0;
        chunk_plan[3] = 24'($urandom_range(2, 600));
        chunk_plan[4] = 24'd5;
        chunk_plan[5] = CHUNK_SIZE_RST;

        // reset
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) send_req(dir_tab[k]);
        stop_requests();

        // random phases, one chunk size each; the last runs without idling
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            if (p == PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            set_chunk_size(chunk_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long output hold-off while requests keep coming
                if (p == 3 && n == 4) hold_reqs++;
                send_req(gen_item());
            end
            stop_requests();
        end

        wait_idle();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_bytes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/che_pkg.sv
hdl/che_slot_mem.sv
hdl/che_emit.sv
hdl/chunk_header_encoder_core.sv
hdl/che_checker.sv
dv/chunk_header_encoder_core_tb.sv
